// ===== src/qnp_pkg.sv =====
package qnp_pkg;

  localparam int FULL_SCALE = 32767;
  localparam int NCOMP = 4;
  localparam int CW = 32;
  localparam int NW = 15;
  localparam int CODEW = 16;
  localparam int TW = 48;
  localparam int TH = TW / 2;
  localparam int SQW = 2 * CW;
  localparam int SW = SQW + 2;
  localparam int EW = 100;
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_STAGES = FRONT_STAGES + NW;

  typedef logic [NW-1:0] mag_t;
  typedef logic [CODEW-1:0] code_t;

  typedef struct packed {
    logic [EW-1:0] rhs;
    logic          neg;
  } front_t;

endpackage

// ===== src/qnp_front.sv =====
module qnp_front (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [qnp_pkg::CW-1:0]   comp,
  output logic [qnp_pkg::SQW-1:0]  sq,
  output qnp_pkg::front_t          front
);
  import qnp_pkg::*;

  logic [CW-1:0]  mag;
  logic [SQW-1:0] sq_a;
  logic [TW-1:0]  t_a;
  logic           neg_a;
  logic [TW-1:0]  hh;
  logic [TW-1:0]  hl;
  logic [TW-1:0]  ll;
  logic           neg_b;

  assign mag = comp[CW-1] ? (~comp + CW'(1)) : comp;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_a  <= SQW'(mag) * SQW'(mag);
      t_a   <= TW'(mag) * TW'(2 * FULL_SCALE);
      neg_a <= comp[CW-1];
      hh    <= TW'(t_a[TW-1:TH]) * TW'(t_a[TW-1:TH]);
      hl    <= TW'(t_a[TW-1:TH]) * TW'(t_a[TH-1:0]);
      ll    <= TW'(t_a[TH-1:0]) * TW'(t_a[TH-1:0]);
      sq    <= sq_a;
      neg_b <= neg_a;
      front.rhs <= (EW'(hh) << (2 * TH)) + (EW'(hl) << (TH + 1)) + EW'(ll);
      front.neg <= neg_b;
    end
  end

endmodule

// ===== src/qnp_search.sv =====
module qnp_search (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [qnp_pkg::SW-1:0]  s,
  input  qnp_pkg::front_t         front,
  output qnp_pkg::mag_t           n,
  output logic                    neg
);
  import qnp_pkg::*;

  mag_t                 cur_n   [0:NW];
  logic signed [EW-1:0] cur_e   [0:NW];
  logic signed [EW-1:0] cur_f   [0:NW];
  logic signed [EW-1:0] cur_s   [0:NW];
  logic signed [EW-1:0] cur_rhs [0:NW];
  logic                 cur_neg [0:NW];

  mag_t                 reg_n   [0:NW-1];
  logic signed [EW-1:0] reg_e   [0:NW-1];
  logic signed [EW-1:0] reg_f   [0:NW-1];
  logic signed [EW-1:0] reg_s   [0:NW-1];
  logic signed [EW-1:0] reg_rhs [0:NW-1];
  logic                 reg_neg [0:NW-1];

  // (2n-1)^2*S and (2n-1)*S, starting from n = 0
  assign cur_n[0]   = '0;
  assign cur_s[0]   = EW'(s);
  assign cur_e[0]   = EW'(s);
  assign cur_f[0]   = -EW'(s);
  assign cur_rhs[0] = front.rhs;
  assign cur_neg[0] = front.neg;

  for (genvar k = 0; k < NW; k++) begin : g_step
    localparam int B = NW - 1 - k;
    mag_t                 cand;
    logic signed [EW-1:0] ec;
    logic                 take;

    assign cand = cur_n[k] | (NW'(1) << B);
    assign ec   = cur_e[k] + (cur_f[k] <<< (B + 2)) + (cur_s[k] <<< (2 * B + 2));
    assign take = ({1'b0, cand} <= 16'(FULL_SCALE)) && (ec <= cur_rhs[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        reg_n[k]   <= take ? cand : cur_n[k];
        reg_e[k]   <= take ? ec : cur_e[k];
        reg_f[k]   <= take ? (cur_f[k] + (cur_s[k] <<< (B + 1))) : cur_f[k];
        reg_s[k]   <= cur_s[k];
        reg_rhs[k] <= cur_rhs[k];
        reg_neg[k] <= cur_neg[k];
      end
    end

    assign cur_n[k+1]   = reg_n[k];
    assign cur_e[k+1]   = reg_e[k];
    assign cur_f[k+1]   = reg_f[k];
    assign cur_s[k+1]   = reg_s[k];
    assign cur_rhs[k+1] = reg_rhs[k];
    assign cur_neg[k+1] = reg_neg[k];
  end

  assign n   = cur_n[NW];
  assign neg = cur_neg[NW];

endmodule

// ===== src/qnp_merge.sv =====
module qnp_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  valid_in,
  input  logic                  ident,
  input  qnp_pkg::mag_t         n   [qnp_pkg::NCOMP],
  input  logic                  neg [qnp_pkg::NCOMP],
  output logic [63:0]           packed_word,
  output logic                  identity_used,
  output logic                  out_valid
);
  import qnp_pkg::*;

  logic [63:0] word;

  always_comb begin
    word = '0;
    for (int i = 0; i < NCOMP; i++) begin
      if ((neg[i] != neg[0]) && (n[i] != '0)) begin
        word[CODEW*i +: CODEW] = code_t'(0) - {1'b0, n[i]};
      end else begin
        word[CODEW*i +: CODEW] = {1'b0, n[i]};
      end
    end
    if (ident) begin
      word = 64'(FULL_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      packed_word   <= word;
      identity_used <= ident;
    end
  end

endmodule

// ===== src/quaternion_normalize_pack_core.sv =====
// Quaternion normalize and pack.
// Input channel: in_valid / in_stall with comp_w, comp_x, comp_y, comp_z
// (signed Q15.16). A transaction completes on a clock edge with in_valid
// high and in_stall low.
// Output channel: out_valid / out_stall with packed_word (four int16, w in
// the low bits) and identity_used.
// Config channel: cfg_valid / cfg_ready with cfg_data, the identity
// threshold on the sum of squares; cfg_ready is always high.
// The pipeline has three front stages (squares, partial products, sums),
// one stage per result bit of the 15-bit rounding search in each of the
// four component lanes, and the output register.
// Throughput is one transaction per cycle; the whole pipeline advances
// together and holds when the output is stalled, which also raises in_stall.
// Reset (rst, synchronous) empties the pipeline and sets the threshold to 43.
module quaternion_normalize_pack_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [31:0]      comp_w,
  input  logic signed [31:0]      comp_x,
  input  logic signed [31:0]      comp_y,
  input  logic signed [31:0]      comp_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [63:0]             packed_word,
  output logic                    identity_used,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [31:0]             cfg_data
);
  import qnp_pkg::*;

  logic                 adv;
  logic [31:0]          min_length_squared;
  logic [PIPE_STAGES-1:0] vpipe;
  logic [NW:0]          ipipe;
  logic [CW-1:0]        comp [NCOMP];
  logic [SQW-1:0]       sq   [NCOMP];
  front_t               front [NCOMP];
  mag_t                 n    [NCOMP];
  logic                 neg  [NCOMP];
  logic [SW-1:0]        s;
  logic [SW-1:0]        s_sum;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  assign comp[0] = comp_w;
  assign comp[1] = comp_x;
  assign comp[2] = comp_y;
  assign comp[3] = comp_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_squared <= 32'd43;
    end else if (cfg_valid) begin
      min_length_squared <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[PIPE_STAGES-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < NCOMP; i++) begin : g_lane
    qnp_front u_front (
      .clk   (clk),
      .adv   (adv),
      .comp  (comp[i]),
      .sq    (sq[i]),
      .front (front[i])
    );

    qnp_search u_search (
      .clk   (clk),
      .adv   (adv),
      .s     (s),
      .front (front[i]),
      .n     (n[i]),
      .neg   (neg[i])
    );
  end

  assign s_sum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s        <= s_sum;
      ipipe[0] <= s_sum <= SW'(min_length_squared);
      ipipe[NW:1] <= ipipe[NW-1:0];
    end
  end

  qnp_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .valid_in      (vpipe[PIPE_STAGES-1]),
    .ident         (ipipe[NW]),
    .n             (n),
    .neg           (neg),
    .packed_word   (packed_word),
    .identity_used (identity_used),
    .out_valid     (out_valid)
  );

endmodule

// ===== tb/sv/quaternion_normalize_pack_core_test.sv =====
module quaternion_normalize_pack_core_test;
  import qnp_pkg::*;

  typedef struct {
    logic [63:0] word;
    logic        ident;
  } pose_code_t;

  class pose_scoreboard;
    logic [31:0] threshold;
    pose_code_t  awaited[$];
    int          errors;

    function new();
      threshold = 32'd43;
      errors = 0;
    endfunction

    function logic [32:0] mag_of(logic [31:0] c);
      return c[31] ? (33'h1_0000_0000 - {1'b0, c}) : {1'b0, c};
    endfunction

    function logic [15:0] round_mag(logic [32:0] a, logic [65:0] s);
      logic [127:0] t, rhs, lhs, odd;
      logic [15:0]  n, cand;
      t = 128'(a) * 2 * FULL_SCALE;
      rhs = t * t;
      n = 0;
      for (int b = NW - 1; b >= 0; b--) begin
        cand = n | (16'd1 << b);
        if (cand > FULL_SCALE) continue;
        odd = 128'(cand) * 2 - 1;
        lhs = odd * odd * 128'(s);
        if (lhs <= rhs) n = cand;
      end
      return n;
    endfunction

    function void note_input(logic [31:0] c[4]);
      logic [32:0] a[4];
      logic [65:0] s;
      logic [15:0] n;
      pose_code_t  e;
      s = 0;
      for (int i = 0; i < 4; i++) begin
        a[i] = mag_of(c[i]);
        s += 66'(a[i]) * 66'(a[i]);
      end
      if (s <= 66'(threshold)) begin
        e.word = 64'(FULL_SCALE);
        e.ident = 1'b1;
      end else begin
        e.word = 0;
        e.ident = 1'b0;
        for (int i = 0; i < 4; i++) begin
          n = round_mag(a[i], s);
          if ((c[i][31] != c[0][31]) && n != 0) n = 16'h0 - n;
          e.word[16*i +: 16] = n;
        end
      end
      awaited.push_back(e);
    endfunction

    function void check_result(logic [63:0] word, logic ident);
      pose_code_t e;
      if (awaited.size() == 0) begin
        $error("unexpected transaction: packed_word %h identity_used %b", word, ident);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (word !== e.word) begin
        $error("packed_word expected %h actual %h", e.word, word);
        errors++;
      end
      if (ident !== e.ident) begin
        $error("identity_used expected %b actual %b", e.ident, ident);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_valid = 0;
  logic [31:0] comp_w = 0, comp_x = 0, comp_y = 0, comp_z = 0, cfg_data = 0;
  logic in_stall, out_valid, identity_used, cfg_ready;
  logic [63:0] packed_word;

  pose_scoreboard sb = new();
  bit quiet = 0, hold_req = 0;
  int stall_left = 0, idle_cycles = 0;

  quaternion_normalize_pack_core dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input('{comp_w, comp_x, comp_y, comp_z});
      if (out_valid && !out_stall) sb.check_result(packed_word, identity_used);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 300;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task send(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    comp_w = w;
    comp_x = x;
    comp_y = y;
    comp_z = z;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task drain;
    in_valid = 0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task set_threshold(logic [31:0] v);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.threshold = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 16) - 8;
      2: return $urandom_range(0, 1 << 17) - (1 << 16);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task random_run(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (k > 4) k = 4;
      send(rand_comp(k), rand_comp(k), rand_comp(k), rand_comp(k));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(0, 0, 0, 0);
    send(6, 3, 1, 1);
    send(6, 3, 1, 2);
    send(32'h0001_0000, 0, 0, 0);
    send(32'hffff_0000, 0, 0, 0);
    send(0, 32'hffff_0000, 0, 0);
    send(0, 0, 0, 32'h0001_0000);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(32'hffff_8000, 32'h0000_8000, 32'hffff_8000, 32'h0000_8000);
    send(1, 32'h7fff_ffff, 0, 0);
    send(32'hffff_ffff, 1, 2, 3);
    send(3, 4, 0, 0);
    send(32'hffff_fffd, 32'hffff_fffc, 0, 0);
    drain();

    set_threshold(0);
    send(0, 0, 0, 0);
    send(0, 0, 0, 1);
    send(32'hffff_ffff, 0, 0, 0);
    random_run(100);
    drain();

    set_threshold(32'hffff_ffff);
    send(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_7fff);
    send(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    hold_req = 1;
    random_run(120);
    drain();

    set_threshold(43);
    random_run(100);
    drain();

    set_threshold($urandom_range(0, 4096));
    quiet = 1;
    random_run(110);
    drain();

    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
